// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion helpers for the span scaler, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SSS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sss_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sss_pkg
// Types, register codes, constants and the edge scaling function shared by
// the span scaler modules.
// ---------------------------------------------------------------------------
package sss_pkg;

  localparam int LINES_DEF      = 160;
  localparam int WINDOWS_DEF    = 2;
  localparam int REG_WINDOWS    = 2;   // windows that own a register set
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int OUT_FIFO_DEPTH = 8;

  localparam int COORD_BASE  = 'h5000;
  localparam int COORD_MAX   = 'h9FFF;
  localparam int LINE_ORIGIN = 79;
  localparam int CENTER      = 120;
  localparam int EDGE_MAX    = 240;
  localparam int RECIP_BITS  = 17;     // quotient bits of 0x10000 / d

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE_A = 3'd0,
    REG_GAIN_A   = 3'd1,
    REG_VDIV_A   = 3'd2,
    REG_ENABLE_B = 3'd3,
    REG_GAIN_B   = 3'd4,
    REG_VDIV_B   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic              mode;
    logic              window;
    logic [7:0]        line;
    logic signed [15:0] span_left;
    logic signed [15:0] span_right;
  } in_item_t;

  typedef struct packed {
    logic        window_id;
    logic [7:0]  line_id;
    logic [15:0] packed_span;
    logic        written;
  } out_item_t;

  typedef struct packed {
    logic        busy;
    logic [15:0] step;
  } recip_stat_t;

  // product / 256 toward zero, recentred and clamped to the visible columns
  function automatic logic [7:0] scale_edge(input logic signed [33:0] p);
    logic signed [33:0] q;
    logic signed [33:0] v;
    q = (p < 0) ? ((p + 34'sd255) >>> 8) : (p >>> 8);
    v = q + 34'(CENTER);
    if (v < 0) begin
      scale_edge = 8'd0;
    end else if (v > 34'(EDGE_MAX)) begin
      scale_edge = 8'(EDGE_MAX);
    end else begin
      scale_edge = v[7:0];
    end
  endfunction

endpackage

// ===== hdl/sss_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sss_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module sss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 320,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== hdl/sss_recip.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sss_recip
// Restoring divider for the row step, 0x10000 / divisor, one quotient bit
// per cycle. Only the low 16 quotient bits are kept.
// ---------------------------------------------------------------------------
module sss_recip (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [15:0]         divisor,
  output sss_pkg::recip_stat_t stat
);

  localparam int CW = $clog2(sss_pkg::RECIP_BITS);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [15:0]   div_r;
  logic [15:0]   rem_r;
  logic [15:0]   q_r;

  logic        num_bit;
  logic [16:0] trial;
  logic        ge;
  logic [15:0] rem_nxt;

  // the dividend has a single one, at its top bit
  assign num_bit = (cnt_r == CW'(sss_pkg::RECIP_BITS - 1));
  assign trial   = {rem_r, num_bit};
  assign ge      = (trial >= {1'b0, div_r});
  assign rem_nxt = ge ? 16'(trial - {1'b0, div_r}) : trial[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(sss_pkg::RECIP_BITS - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= divisor;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[14:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.step = q_r;

endmodule

// ===== hdl/sss_out_fifo.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// sss_out_fifo
// Result queue behind the pipeline; the top level reserves a slot for every
// lookup request it takes, so a push always finds room.
// ---------------------------------------------------------------------------
module sss_out_fifo #(
  parameter int DEPTH = sss_pkg::OUT_FIFO_DEPTH,
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sss_pkg::out_item_t push_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sss_pkg::out_item_t out_data
);

  sss_pkg::out_item_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          pop;

  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  `SSS_ASSERT_IMPL(a_fifo_no_overflow, push && !pop, count_r != CW'(DEPTH), "result fifo overflow")
  `SSS_ASSERT_NEXT(a_fifo_pop_count, pop && !push, count_r == $past(count_r) - 1'b1, "fifo count slip")

endmodule

// ===== hdl/scanline_span_scaler.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// scanline_span_scaler
// Span table lookup and horizontal scaling for two display windows.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall   | sss_pkg::in_item_t
//   out_    | output    | out_valid / out_stall | sss_pkg::out_item_t
//   cfg_    | input     | cfg_we                | cfg_idx, cfg_wdata
//
// One item per cycle while in_stall is low; a lookup's result passes in order
// through row multiply, RAM read, edge multiplies, round/clamp and result queue.
// A vdiv write starts the step divider of its register set, with in_stall held high while it runs.
// No clearing pass after reset: the span RAM holds nothing until loaded.
// Up to 8 requests may be outstanding; in_stall rises when the queue is booked.
// ---------------------------------------------------------------------------
module scanline_span_scaler #(
  parameter int LINES   = sss_pkg::LINES_DEF,
  parameter int WINDOWS = sss_pkg::WINDOWS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  sss_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output sss_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [sss_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [sss_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int   DEPTH   = WINDOWS * LINES;
  localparam int   AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int   QDEPTH  = sss_pkg::OUT_FIFO_DEPTH;
  localparam int   PW      = $clog2(QDEPTH + 1);
  localparam logic WIN1_OK = (WINDOWS > 1);
  localparam logic [8:0] LINES_CMP = 9'(LINES);

  // configuration
  logic        enable_r [sss_pkg::REG_WINDOWS];
  logic [15:0] gain_r   [sss_pkg::REG_WINDOWS];
  logic [15:0] vdiv_r   [sss_pkg::REG_WINDOWS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sss_pkg::REG_WINDOWS; i++) begin
        enable_r[i] <= 1'b0;
        gain_r[i]   <= '0;
        vdiv_r[i]   <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_idx)
        sss_pkg::REG_ENABLE_A: enable_r[0] <= cfg_wdata[0];
        sss_pkg::REG_GAIN_A:   gain_r[0]   <= cfg_wdata;
        sss_pkg::REG_VDIV_A:   vdiv_r[0]   <= cfg_wdata;
        sss_pkg::REG_ENABLE_B: enable_r[1] <= cfg_wdata[0];
        sss_pkg::REG_GAIN_B:   gain_r[1]   <= cfg_wdata;
        sss_pkg::REG_VDIV_B:   vdiv_r[1]   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // row step dividers, one per register set
  sss_pkg::recip_stat_t rstat [sss_pkg::REG_WINDOWS];
  logic                 div_busy;

  for (genvar g = 0; g < sss_pkg::REG_WINDOWS; g++) begin : g_recip
    localparam sss_pkg::cfg_reg_e VDIV_IDX = (g == 0) ? sss_pkg::REG_VDIV_A
                                                      : sss_pkg::REG_VDIV_B;
    logic start;
    assign start = cfg_we && (cfg_idx == VDIV_IDX);
    sss_recip u_recip (
      .clk     (clk),
      .rst_n   (rst_n),
      .start   (start),
      .divisor (cfg_wdata),
      .stat    (rstat[g])
    );
  end

  assign div_busy = rstat[0].busy || rstat[1].busy;

  // transfer and outstanding request count
  logic          acc;
  logic          pop;
  logic [PW-1:0] pend_r;
  logic [PW-1:0] pend_nxt;

  assign in_stall = div_busy || (pend_r == PW'(QDEPTH));
  assign acc      = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  always_comb begin
    pend_nxt = pend_r;
    if (acc && in_data.mode && !pop) begin
      pend_nxt = pend_r + 1'b1;
    end else if (!(acc && in_data.mode) && pop) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // stage 1: window checks, row offset multiply
  logic              s1_valid_r;
  sss_pkg::in_item_t s1_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_item_r <= in_data;
    end
  end

  logic               w1;
  logic               win_ok1;
  logic               line_ok1;
  logic               written1;
  logic               active1;
  logic signed [8:0]  ldiff1;
  logic signed [16:0] step1;
  logic signed [25:0] prod1;

  assign w1       = s1_item_r.window;
  assign win_ok1  = !w1 || WIN1_OK;
  assign line_ok1 = ({1'b0, s1_item_r.line} < LINES_CMP);
  assign written1 = win_ok1 && enable_r[w1] && line_ok1;
  assign active1  = written1 && (gain_r[w1] != '0) && (vdiv_r[w1] != '0);
  assign ldiff1   = $signed({1'b0, s1_item_r.line}) - 9'sd79;
  assign step1    = $signed({1'b0, rstat[w1].step});
  assign prod1    = ldiff1 * step1;

  // stage 2: source row, table access
  logic               s2_valid_r;
  logic               s2_mode_r;
  logic               s2_win_r;
  logic [7:0]         s2_line_r;
  logic [31:0]        s2_span_r;
  logic               s2_win_ok_r;
  logic               s2_line_ok_r;
  logic               s2_written_r;
  logic               s2_active_r;
  logic signed [25:0] s2_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_mode_r    <= s1_item_r.mode;
    s2_win_r     <= w1;
    s2_line_r    <= s1_item_r.line;
    s2_span_r    <= {s1_item_r.span_right, s1_item_r.span_left};
    s2_win_ok_r  <= win_ok1;
    s2_line_ok_r <= line_ok1;
    s2_written_r <= written1;
    s2_active_r  <= active1;
    s2_prod_r    <= prod1;
  end

  logic signed [26:0] coord2;
  logic               coord_ok2;
  logic [7:0]         row2;
  logic               hit2;
  logic [AW-1:0]      base2;
  logic               ram_we;
  logic               ram_re;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  logic [31:0]        ram_rdata;

  assign coord2    = 27'(s2_prod_r) + 27'(sss_pkg::COORD_BASE);
  assign coord_ok2 = !coord2[26] && (coord2 <= 27'(sss_pkg::COORD_MAX));
  assign row2      = coord2[15:8];
  assign hit2      = s2_active_r && coord_ok2 && ({1'b0, row2} < LINES_CMP);
  assign base2     = s2_win_r ? AW'(LINES) : '0;

  assign ram_we    = s2_valid_r && !s2_mode_r && s2_win_ok_r && s2_line_ok_r;
  assign ram_waddr = AW'(base2 + AW'(s2_line_r));
  assign ram_re    = s2_valid_r && s2_mode_r && hit2;
  assign ram_raddr = AW'(base2 + AW'(row2));

  sss_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_span_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s2_span_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // stage 3: span check, edge multiplies
  logic       s3_valid_r;
  logic       s3_win_r;
  logic [7:0] s3_line_r;
  logic       s3_written_r;
  logic       s3_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r && s2_mode_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_win_r     <= s2_win_r;
    s3_line_r    <= s2_line_r;
    s3_written_r <= s2_written_r;
    s3_hit_r     <= hit2;
  end

  logic signed [15:0] a3;
  logic signed [15:0] b3;
  logic signed [16:0] ea3;
  logic signed [16:0] eb3;
  logic signed [16:0] gain3;
  logic signed [33:0] pl3;
  logic signed [33:0] pr3;

  assign a3    = $signed(ram_rdata[15:0]);
  assign b3    = $signed(ram_rdata[31:16]);
  assign ea3   = 17'(a3) - 17'sd120;
  assign eb3   = 17'(b3) - 17'sd120;
  assign gain3 = $signed({1'b0, gain_r[s3_win_r]});
  assign pl3   = ea3 * gain3;
  assign pr3   = eb3 * gain3;

  // stage 4: round, clamp, pack
  logic               s4_valid_r;
  logic               s4_win_r;
  logic [7:0]         s4_line_r;
  logic               s4_written_r;
  logic               s4_ok_r;
  logic signed [33:0] s4_pl_r;
  logic signed [33:0] s4_pr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_win_r     <= s3_win_r;
    s4_line_r    <= s3_line_r;
    s4_written_r <= s3_written_r;
    s4_ok_r      <= s3_hit_r && (a3 < b3);
    s4_pl_r      <= pl3;
    s4_pr_r      <= pr3;
  end

  sss_pkg::out_item_t res4;

  always_comb begin
    res4.window_id   = s4_win_r;
    res4.line_id     = s4_line_r;
    res4.written     = s4_written_r;
    res4.packed_span = s4_ok_r ? {sss_pkg::scale_edge(s4_pl_r), sss_pkg::scale_edge(s4_pr_r)}
                               : 16'd0;
  end

  sss_out_fifo #(
    .DEPTH (QDEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s4_valid_r),
    .push_data (res4),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `SSS_ASSERT_IMPL(a_pend_bound, 1'b1, pend_r <= PW'(QDEPTH), "outstanding requests exceed queue")
  `SSS_ASSERT_IMPL(a_ram_excl, ram_we, !ram_re, "span load and lookup in one cycle")

endmodule
